@@ rtl/zvrs_pkg.sv @@
`default_nettype none
package zvrs_pkg;

  localparam int FRAC     = 24;
  localparam int Z_W      = 33;
  localparam int MANT_W   = 32;
  localparam int POS_W    = 6;
  localparam int LOG_W    = POS_W + FRAC;
  localparam int EXP_W    = 31;
  localparam int QUO_W    = 32;
  localparam int SHAPE_W  = 28;
  localparam int ROOT_W   = 31;
  localparam int TWOPOW_W = 33;

  localparam logic [1:0] REG_SHAPE  = 2'd0;
  localparam logic [1:0] REG_ROOT   = 2'd1;
  localparam logic [1:0] REG_TWOPOW = 2'd2;

  // Q30 value of 2^(2^-k): k successive integer square roots starting from 2.0.
  function automatic logic [31:0] root_val(input int k);
    logic [63:0] r;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    r = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      n    = r << 30;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      r = res;
    end
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/zeta_variate_rejection_sampler_top.sv @@
// Channel  | Handshake                    | Payload
// ---------+------------------------------+------------------------------------
// trial in | start, accepted when !busy   | uniform_u, uniform_v
// sample   | strobe, one cycle per beat   | sample
// config   | APB write/read, pready = 1   | paddr, pwdata, prdata
//
// One trial beat is taken every cycle while busy is low; the pipeline has no back pressure.
// A surviving trial raises strobe after its beat has passed the two 26-stage log2
// units, the two 24-stage exp2 units, the 32-stage divider and the 14 stages of
// split multipliers for the final test.
// busy is high only during reset and the cycle after it.
// The user must write configuration only while no trial is in flight; the block does not enforce it.
`default_nettype none
module zeta_variate_rejection_sampler_top #(
  parameter int SAMPLE_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [31:0]            uniform_u,
  input  logic [31:0]            uniform_v,
  output logic                   strobe,
  output logic [SAMPLE_BITS-1:0] sample,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  import zvrs_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int T_W   = 40;
  localparam int P1_W  = SB + 32;
  localparam int P2_W  = P1_W + T_W;
  localparam int P3_W  = P2_W + TWOPOW_W;
  localparam int R_W   = T_W + TWOPOW_W;
  localparam int XV_W  = SB + 32;

  localparam logic signed [30:0] LU_BIAS  = 31'sd536870912;
  localparam logic [LOG_W-1:0]   LT_BIAS  = LOG_W'(31) << FRAC;
  localparam logic [T_W-1:0]     ONE_T    = T_W'(1) << FRAC;
  localparam logic [TWOPOW_W-1:0] ONE_B   = TWOPOW_W'(1) << FRAC;

  // Configuration registers.
  logic [SHAPE_W-1:0]         shape_minus_one;
  logic signed [ROOT_W-1:0]   root_exponent;
  logic [TWOPOW_W-1:0]        two_pow_shape;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_minus_one <= SHAPE_W'(1) << FRAC;
      root_exponent   <= -31'sd16777216;
      two_pow_shape   <= TWOPOW_W'(2) << FRAC;
    end else if (wr_en) begin
      unique case (paddr[4:3])
        REG_SHAPE:  shape_minus_one <= pwdata[SHAPE_W-1:0];
        REG_ROOT:   root_exponent   <= pwdata[ROOT_W-1:0];
        REG_TWOPOW: two_pow_shape   <= pwdata[TWOPOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_SHAPE:  prdata = 64'(shape_minus_one);
      REG_ROOT:   prdata = {33'b0, root_exponent};
      REG_TWOPOW: prdata = 64'(two_pow_shape);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Input register. A zero U is dropped here.
  logic        t0_v;
  logic [31:0] t0_u;
  logic [31:0] t0_uv;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
    end else begin
      t0_v <= start && !busy && (uniform_u != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    t0_u  <= uniform_u;
    t0_uv <= uniform_v;
  end

  // log2(U) in Q24, before the bias of 32.
  logic             l1_v;
  logic [LOG_W-1:0] l1;
  logic [31:0]      l1_uv;

  zvrs_log2 #(.SW(32)) u_log_u (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t0_v),
    .in_z      ({1'b0, t0_u}),
    .in_side   (t0_uv),
    .out_valid (l1_v),
    .out_log   (l1),
    .out_side  (l1_uv)
  );

  logic signed [30:0] lu;
  logic signed [61:0] prod_e;
  logic               t1_v;
  logic signed [61:0] t1_prod;
  logic [31:0]        t1_uv;

  assign lu     = $signed({1'b0, l1}) - LU_BIAS;
  assign prod_e = lu * root_exponent;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else begin
      t1_v <= l1_v;
    end
  end

  always_ff @(posedge clk) begin
    t1_prod <= prod_e;
    t1_uv   <= l1_uv;
  end

  // Split e into integer and fraction; a negative or too large exponent rejects.
  logic [12:0]      e_int;
  logic             t2_v;
  logic [FRAC-1:0]  t2_f;
  logic [POS_W-1:0] t2_ip;
  logic [31:0]      t2_uv;

  assign e_int = t1_prod[60:48];

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
    end else begin
      t2_v <= t1_v && !t1_prod[61] && (e_int < 13'(SB));
    end
  end

  always_ff @(posedge clk) begin
    t2_f  <= t1_prod[47:24];
    t2_ip <= e_int[POS_W-1:0];
    t2_uv <= t1_uv;
  end

  logic             e1_v;
  logic [EXP_W-1:0] e1_acc;
  logic [POS_W+31:0] e1_side;

  zvrs_exp2 #(.SW(POS_W + 32)) u_exp_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t2_v),
    .in_f      (t2_f),
    .in_side   ({t2_ip, t2_uv}),
    .out_valid (e1_v),
    .out_acc   (e1_acc),
    .out_side  (e1_side)
  );

  logic [POS_W-1:0] e1_ip;
  logic [63:0]      acc_wide;
  logic [63:0]      x_wide;
  logic             t3_v;
  logic [SB-1:0]    t3_x;
  logic [31:0]      t3_uv;

  assign e1_ip    = e1_side[POS_W+31:32];
  assign acc_wide = 64'(e1_acc);
  assign x_wide   = (e1_ip >= POS_W'(30)) ? (acc_wide << (e1_ip - POS_W'(30)))
                                          : (acc_wide >> (POS_W'(30) - e1_ip));

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_v <= 1'b0;
    end else begin
      t3_v <= e1_v && (x_wide != 64'd0) && ((x_wide >> SB) == 64'd0);
    end
  end

  always_ff @(posedge clk) begin
    t3_x  <= x_wide[SB-1:0];
    t3_uv <= e1_side[31:0];
  end

  // floor(2^31 / X) for log2(1 + 1/X).
  logic             dv_v;
  logic [QUO_W-1:0] dv_q;
  logic [XV_W-1:0]  dv_side;

  zvrs_div #(.DW(SB), .SW(XV_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t3_v),
    .in_d      (t3_x),
    .in_side   ({t3_x, t3_uv}),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  logic             l2_v;
  logic [LOG_W-1:0] l2;
  logic [XV_W-1:0]  l2_side;

  zvrs_log2 #(.SW(XV_W)) u_log_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_v),
    .in_z      ({1'b0, dv_q} + (Z_W'(1) << 31)),
    .in_side   (dv_side),
    .out_valid (l2_v),
    .out_log   (l2),
    .out_side  (l2_side)
  );

  logic [FRAC:0]      lt;
  logic [52:0]        g_prod;
  logic               t5_v;
  logic [FRAC+3:0]    t5_g;
  logic [XV_W-1:0]    t5_side;

  assign lt     = (FRAC + 1)'(l2 - LT_BIAS);
  assign g_prod = lt * shape_minus_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      t5_v <= 1'b0;
    end else begin
      t5_v <= l2_v;
    end
  end

  always_ff @(posedge clk) begin
    t5_g    <= g_prod[51:24];
    t5_side <= l2_side;
  end

  logic             e2_v;
  logic [EXP_W-1:0] e2_acc;
  logic [XV_W+3:0]  e2_side;

  zvrs_exp2 #(.SW(XV_W + 4)) u_exp_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t5_v),
    .in_f      (t5_g[FRAC-1:0]),
    .in_side   ({t5_g[FRAC+3:FRAC], t5_side}),
    .out_valid (e2_v),
    .out_acc   (e2_acc),
    .out_side  (e2_side)
  );

  logic [3:0]      e2_ip;
  logic [T_W-1:0]  t_wide;
  logic [T_W-1:0]  t_val;
  logic            t6_v;
  logic [T_W-1:0]  t6_t;
  logic [T_W-1:0]  t6_dt;
  logic [SB-1:0]   t6_x;
  logic [31:0]     t6_uv;

  assign e2_ip  = e2_side[XV_W+3:XV_W];
  assign t_wide = T_W'(e2_acc);
  assign t_val  = (e2_ip >= 4'd6) ? (t_wide << (e2_ip - 4'd6))
                                  : (t_wide >> (4'd6 - e2_ip));

  // A shape power below 1.0 makes the right side negative: always rejected.
  always_ff @(posedge clk) begin
    if (rst) begin
      t6_v <= 1'b0;
    end else begin
      t6_v <= e2_v && (two_pow_shape >= ONE_B);
    end
  end

  always_ff @(posedge clk) begin
    t6_t  <= t_val;
    t6_dt <= t_val - ONE_T;
    t6_x  <= e2_side[XV_W-1:32];
    t6_uv <= e2_side[31:0];
  end

  // Exact test: V*X*(T-1)*b against T*(b-1)*2^32.
  logic                   m1_v;
  logic [P1_W-1:0]        m1_p;
  logic [2*T_W+SB-1:0]    m1_side;

  zvrs_mul #(.AW(SB), .BW(32), .SW(2 * T_W + SB)) u_mul_vx (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t6_v),
    .in_a      (t6_x),
    .in_b      (t6_uv),
    .in_side   ({t6_t, t6_dt, t6_x}),
    .out_valid (m1_v),
    .out_p     (m1_p),
    .out_side  (m1_side)
  );

  logic                m2_v;
  logic [P2_W-1:0]     m2_p;
  logic [T_W+SB-1:0]   m2_side;

  zvrs_mul #(.AW(P1_W), .BW(T_W), .SW(T_W + SB)) u_mul_dt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m1_v),
    .in_a      (m1_p),
    .in_b      (m1_side[T_W+SB-1:SB]),
    .in_side   ({m1_side[2*T_W+SB-1:T_W+SB], m1_side[SB-1:0]}),
    .out_valid (m2_v),
    .out_p     (m2_p),
    .out_side  (m2_side)
  );

  logic                m3_v;
  logic [P3_W-1:0]     m3_p;
  logic [T_W+SB-1:0]   m3_side;

  zvrs_mul #(.AW(P2_W), .BW(TWOPOW_W), .SW(T_W + SB)) u_mul_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m2_v),
    .in_a      (m2_p),
    .in_b      (two_pow_shape),
    .in_side   (m2_side),
    .out_valid (m3_v),
    .out_p     (m3_p),
    .out_side  (m3_side)
  );

  logic [TWOPOW_W-1:0]  b_minus_one;
  logic                 m4_v;
  logic [R_W-1:0]       m4_p;
  logic [P3_W+SB-1:0]   m4_side;

  assign b_minus_one = two_pow_shape - ONE_B;

  zvrs_mul #(.AW(T_W), .BW(TWOPOW_W), .SW(P3_W + SB)) u_mul_rhs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m3_v),
    .in_a      (m3_side[T_W+SB-1:SB]),
    .in_b      (b_minus_one),
    .in_side   ({m3_p, m3_side[SB-1:0]}),
    .out_valid (m4_v),
    .out_p     (m4_p),
    .out_side  (m4_side)
  );

  logic [P3_W-1:0] lhs;
  logic [P3_W-1:0] rhs;

  assign lhs = m4_side[P3_W+SB-1:SB];
  assign rhs = P3_W'({m4_p, 32'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= m4_v && !(lhs > rhs);
    end
  end

  always_ff @(posedge clk) begin
    sample <= m4_side[SB-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/zvrs_log2.sv @@
`default_nettype none
module zvrs_log2 #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [zvrs_pkg::Z_W-1:0]      in_z,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic [zvrs_pkg::LOG_W-1:0]    out_log,
  output logic [SW-1:0]                 out_side
);
  import zvrs_pkg::*;

  logic [POS_W-1:0]  pos;
  logic              enc_v;
  logic [Z_W-1:0]    enc_z;
  logic [POS_W-1:0]  enc_p;
  logic [SW-1:0]     enc_side;
  logic              nrm_v;
  logic [MANT_W-1:0] nrm_m;
  logic [POS_W-1:0]  nrm_p;
  logic [SW-1:0]     nrm_side;

  logic              v_r    [0:FRAC-1];
  logic [MANT_W-1:0] m_r    [0:FRAC-1];
  logic [FRAC-1:0]   fr_r   [0:FRAC-1];
  logic [POS_W-1:0]  p_r    [0:FRAC-1];
  logic [SW-1:0]     side_r [0:FRAC-1];

  always_comb begin
    pos = '0;
    for (int i = 0; i < Z_W; i++) begin
      if (in_z[i]) pos = POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_v <= 1'b0;
      nrm_v <= 1'b0;
    end else begin
      enc_v <= in_valid;
      nrm_v <= enc_v;
    end
  end

  // The mantissa is z scaled so that its top set bit lands on bit 31.
  always_ff @(posedge clk) begin
    enc_z    <= in_z;
    enc_p    <= pos;
    enc_side <= in_side;
    nrm_m    <= MANT_W'(({31'b0, enc_z} << 31) >> enc_p);
    nrm_p    <= enc_p;
    nrm_side <= enc_side;
  end

  for (genvar k = 0; k < FRAC; k++) begin : g_sq
    logic              v_in;
    logic [MANT_W-1:0] m_in;
    logic [FRAC-1:0]   fr_in;
    logic [POS_W-1:0]  p_in;
    logic [SW-1:0]     side_in;
    logic [63:0]       sq;
    logic [32:0]       sq_top;

    if (k == 0) begin : g_first
      assign v_in    = nrm_v;
      assign m_in    = nrm_m;
      assign fr_in   = '0;
      assign p_in    = nrm_p;
      assign side_in = nrm_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign m_in    = m_r[k-1];
      assign fr_in   = fr_r[k-1];
      assign p_in    = p_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign sq     = m_in * m_in;
    assign sq_top = sq[63:31];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    // A square of 2.0 or more yields a one bit and is halved back into range.
    always_ff @(posedge clk) begin
      m_r[k]    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
      fr_r[k]   <= {fr_in[FRAC-2:0], sq_top[32]};
      p_r[k]    <= p_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[FRAC-1];
  assign out_log   = {p_r[FRAC-1], fr_r[FRAC-1]};
  assign out_side  = side_r[FRAC-1];

endmodule
`default_nettype wire

@@ rtl/zvrs_exp2.sv @@
`default_nettype none
module zvrs_exp2 #(
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [zvrs_pkg::FRAC-1:0]    in_f,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [zvrs_pkg::EXP_W-1:0]   out_acc,
  output logic [SW-1:0]                out_side
);
  import zvrs_pkg::*;

  logic             v_r    [0:FRAC-1];
  logic [EXP_W-1:0] acc_r  [0:FRAC-1];
  logic [FRAC-1:0]  f_r    [0:FRAC-1];
  logic [SW-1:0]    side_r [0:FRAC-1];

  for (genvar s = 0; s < FRAC; s++) begin : g_bit
    localparam logic [EXP_W-1:0] ROOT = EXP_W'(root_val(s + 1));
    logic             v_in;
    logic [EXP_W-1:0] acc_in;
    logic [FRAC-1:0]  f_in;
    logic [SW-1:0]    side_in;
    logic [61:0]      prod;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign acc_in  = EXP_W'(1) << 30;
      assign f_in    = in_f;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign acc_in  = acc_r[s-1];
      assign f_in    = f_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign prod = acc_in * ROOT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end

    // Fraction bits are taken from the most significant one down.
    always_ff @(posedge clk) begin
      acc_r[s]  <= f_in[FRAC-1-s] ? prod[60:30] : acc_in;
      f_r[s]    <= f_in;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = v_r[FRAC-1];
  assign out_acc   = acc_r[FRAC-1];
  assign out_side  = side_r[FRAC-1];

endmodule
`default_nettype wire

@@ rtl/zvrs_div.sv @@
`default_nettype none
module zvrs_div #(
  parameter int DW = 48,
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [DW-1:0]                in_d,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [zvrs_pkg::QUO_W-1:0]   out_q,
  output logic [SW-1:0]                out_side
);
  import zvrs_pkg::*;

  logic             v_r    [0:QUO_W-1];
  logic [QUO_W-1:0] r_r    [0:QUO_W-1];
  logic [QUO_W-1:0] q_r    [0:QUO_W-1];
  logic [DW-1:0]    d_r    [0:QUO_W-1];
  logic [SW-1:0]    side_r [0:QUO_W-1];

  // Restoring division of 2^31 by d, one quotient bit per stage.
  for (genvar s = 0; s < QUO_W; s++) begin : g_bit
    localparam int B = QUO_W - 1 - s;
    logic             v_in;
    logic [QUO_W-1:0] r_in;
    logic [QUO_W-1:0] q_in;
    logic [DW-1:0]    d_in;
    logic [SW-1:0]    side_in;
    logic [63:0]      d_wide;
    logic             fits;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign r_in    = QUO_W'(1) << (QUO_W - 1);
      assign q_in    = '0;
      assign d_in    = in_d;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign r_in    = r_r[s-1];
      assign q_in    = q_r[s-1];
      assign d_in    = d_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign d_wide = 64'(d_in);
    assign fits   = (d_wide[63:32] == 32'd0) && (d_wide[31:0] <= (r_in >> B));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      r_r[s]    <= fits ? (r_in - (d_wide[31:0] << B)) : r_in;
      q_r[s]    <= fits ? (q_in | (QUO_W'(1) << B)) : q_in;
      d_r[s]    <= d_in;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_q     = q_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule
`default_nettype wire

@@ rtl/zvrs_mul.sv @@
`default_nettype none
module zvrs_mul #(
  parameter int AW = 64,
  parameter int BW = 32,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [AW-1:0]    in_a,
  input  logic [BW-1:0]    in_b,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [AW+BW-1:0] out_p,
  output logic [SW-1:0]    out_side
);

  localparam int NA    = (AW + 31) / 32;
  localparam int NB    = (BW + 31) / 32;
  localparam int NS    = 2 * NB;
  localparam int AP_W  = 32 * NA;
  localparam int BP_W  = 32 * NB;
  localparam int ACC_W = 32 * (NA + NB);

  logic             v_r    [0:NS-1];
  logic [AP_W-1:0]  a_r    [0:NS-1];
  logic [BP_W-1:0]  b_r    [0:NS-1];
  logic [ACC_W-1:0] acc_r  [0:NS-1];
  logic [SW-1:0]    side_r [0:NS-1];
  logic [63:0]      pp_r   [0:NB-1][0:NA-1];

  // Each 32-bit digit of b takes two stages: partial products, then accumulate.
  for (genvar j = 0; j < NB; j++) begin : g_digit
    logic             v_in;
    logic [AP_W-1:0]  a_in;
    logic [BP_W-1:0]  b_in;
    logic [ACC_W-1:0] acc_in;
    logic [SW-1:0]    side_in;
    logic [ACC_W-1:0] ev;
    logic [ACC_W-1:0] od;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign a_in    = AP_W'(in_a);
      assign b_in    = BP_W'(in_b);
      assign acc_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[2*j-1];
      assign a_in    = a_r[2*j-1];
      assign b_in    = b_r[2*j-1];
      assign acc_in  = acc_r[2*j-1];
      assign side_in = side_r[2*j-1];
    end

    // Even and odd limb products do not overlap, so each set packs by OR.
    always_comb begin
      ev = '0;
      od = '0;
      for (int i = 0; i < NA; i++) begin
        if (i % 2 == 0) begin
          ev = ev | (ACC_W'(pp_r[j][i]) << (32 * i));
        end else begin
          od = od | (ACC_W'(pp_r[j][i]) << (32 * i));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[2*j]   <= 1'b0;
        v_r[2*j+1] <= 1'b0;
      end else begin
        v_r[2*j]   <= v_in;
        v_r[2*j+1] <= v_r[2*j];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < NA; i++) begin
        pp_r[j][i] <= a_in[32*i +: 32] * b_in[32*j +: 32];
      end
      a_r[2*j]      <= a_in;
      b_r[2*j]      <= b_in;
      acc_r[2*j]    <= acc_in;
      side_r[2*j]   <= side_in;
      a_r[2*j+1]    <= a_r[2*j];
      b_r[2*j+1]    <= b_r[2*j];
      acc_r[2*j+1]  <= acc_r[2*j] + (ev << (32 * j)) + (od << (32 * j));
      side_r[2*j+1] <= side_r[2*j];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_p     = acc_r[NS-1][AW+BW-1:0];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire
